// ===== sv/ihv_pkg.sv =====
// Shared types, constants and helper functions of the image header validator.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ihv_pkg;

    localparam int BYTE_COUNT_BITS_DEF = 32;

    localparam logic [30:0] MAX_DIMENSION_RESET = 31'd4096;
    localparam logic [61:0] MAX_PIXELS_RESET = 62'd16777216;

    localparam logic [31:0] CRC_POLY = 32'hedb88320;
    localparam logic [31:0] CRC_INIT = 32'hffffffff;

    localparam logic [31:0] TYPE_IHDR = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT = 32'h49444154;
    localparam logic [31:0] TYPE_IEND = 32'h49454e44;
    localparam logic [31:0] IHDR_LENGTH = 32'd13;

    localparam logic [7:0] JPEG_FILL = 8'hff;
    localparam logic [7:0] JPEG_SOI = 8'hd8;
    localparam logic [7:0] JPEG_EOI = 8'hd9;
    localparam logic [7:0] JPEG_SOS = 8'hda;
    localparam logic [7:0] JPEG_TEM = 8'h01;
    localparam logic [7:0] JPEG_RST_FIRST = 8'hd0;
    localparam logic [7:0] JPEG_RST_LAST = 8'hd7;
    localparam logic [7:0] JPEG_SOF_BASE = 8'hc0;
    localparam logic [15:0] SOF_MIN_LENGTH = 16'd7;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_PNG  = 2'd1,
        FMT_JPEG = 2'd2
    } format_t;

    typedef enum logic {
        CFG_MAX_DIMENSION = 1'b0,
        CFG_MAX_PIXELS    = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        PNG_SIG, PNG_LEN, PNG_TYPE, PNG_DATA, PNG_CRC, PNG_HALT
    } png_phase_t;

    typedef enum logic [2:0] {
        JP_START0, JP_START1, JP_MARKER, JP_LEN_HI, JP_LEN_LO, JP_SKIP, JP_SOF, JP_HALT
    } jpeg_phase_t;

    // One accepted byte as seen by the parsers.
    typedef struct packed {
        logic       accept;
        logic       last;
        logic [7:0] data;
    } byte_req_t;

    // Verdict of one parser for the byte being accepted.
    typedef struct packed {
        logic        valid;
        logic [30:0] width;
        logic [30:0] height;
    } dims_t;

    function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0: r = 8'h89;
            3'd1: r = 8'h50;
            3'd2: r = 8'h4e;
            3'd3: r = 8'h47;
            3'd4: r = 8'h0d;
            3'd5: r = 8'h0a;
            3'd6: r = 8'h1a;
            3'd7: r = 8'h0a;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

    function automatic logic is_sof(input logic [7:0] m);
        return (m[7:4] == JPEG_SOF_BASE[7:4]) && (m != 8'hc4) && (m != 8'hc8) && (m != 8'hcc);
    endfunction

endpackage

`default_nettype wire

// ===== sv/image_header_validator_top.sv =====
// Image header validator: streams a PNG or JPEG file one byte per request
// and reports the format, dimensions and a limit check on the final byte.
// Input channel: in_valid/in_ready with data_byte and is_last. A file ends
// with the request whose is_last is high; the next request starts a new file.
// Output channel: out_valid/out_ready with format, width, height, accepted;
// exactly one result per file, none for other bytes.
// Throughput: one byte per cycle unless a waiting result stalls the pipeline.
// Both parsers and the CRC-32 update take one byte in the cycle it is accepted.
// After the final byte is accepted, the result passes through the verdict
// register, the width-times-height multiply register and the output register
// before it is presented.
// Configuration: cfg_write_en with cfg_index 0 writes max_dimension, index 1
// writes max_pixels; write only while no file is in flight.
// Reset clears both parsers, empties the pipeline and loads max_dimension
// 4096 and max_pixels 16777216.
// When the receiver holds out_ready low with a result waiting, the whole
// pipeline stalls and in_ready drops until the result is taken.
// Depends on ihv_pkg, ihv_png, ihv_jpeg and ihv_limits.
`timescale 1ns / 1ps
`default_nettype none

module image_header_validator_top
    import ihv_pkg::*;
#(
    parameter int BYTE_COUNT_BITS = BYTE_COUNT_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        is_last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       format,
    output logic [30:0]      width,
    output logic [30:0]      height,
    output logic             accepted,
    input  wire logic        cfg_write_en,
    input  wire logic        cfg_index,
    input  wire logic [61:0] cfg_data
);

    logic                       advance;
    byte_req_t                  req;
    dims_t                      png_verdict;
    dims_t                      jpeg_verdict;
    logic [BYTE_COUNT_BITS-1:0] byte_count_reg, byte_count_next;
    logic [30:0]                max_dimension_reg;
    logic [61:0]                max_pixels_reg;
    format_t                    sel_format;
    logic [30:0]                sel_width;
    logic [30:0]                sel_height;
    format_t                    out_format;

    assign advance = !out_valid || out_ready;
    assign in_ready = advance;

    assign req.accept = in_valid && advance;
    assign req.last = is_last;
    assign req.data = data_byte;

    ihv_png u_png (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .verdict (png_verdict)
    );

    ihv_jpeg u_jpeg (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .verdict (jpeg_verdict)
    );

    // The count saturates; it only feeds the minimum JPEG length check.
    assign byte_count_next = (&byte_count_reg) ? byte_count_reg
                                               : byte_count_reg + BYTE_COUNT_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
        end
        else if (req.accept)
        begin
            byte_count_reg <= is_last ? '0 : byte_count_next;
        end
    end

    always_comb
    begin
        sel_format = FMT_NONE;
        sel_width = 31'd0;
        sel_height = 31'd0;
        if (png_verdict.valid)
        begin
            sel_format = FMT_PNG;
            sel_width = png_verdict.width;
            sel_height = png_verdict.height;
        end
        else if (jpeg_verdict.valid && (byte_count_next >= BYTE_COUNT_BITS'(4)))
        begin
            sel_format = FMT_JPEG;
            sel_width = jpeg_verdict.width;
            sel_height = jpeg_verdict.height;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dimension_reg <= MAX_DIMENSION_RESET;
            max_pixels_reg <= MAX_PIXELS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MAX_DIMENSION: max_dimension_reg <= cfg_data[30:0];
                CFG_MAX_PIXELS: max_pixels_reg <= cfg_data;
                default: max_pixels_reg <= max_pixels_reg;
            endcase
        end
    end

    ihv_limits u_limits (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .verdict_valid  (req.accept && is_last),
        .verdict_format (sel_format),
        .verdict_width  (sel_width),
        .verdict_height (sel_height),
        .max_dimension  (max_dimension_reg),
        .max_pixels     (max_pixels_reg),
        .out_valid      (out_valid),
        .format         (out_format),
        .width          (width),
        .height         (height),
        .accepted       (accepted)
    );

    assign format = out_format;

`ifndef SYNTHESIS
    a_none_has_no_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (format == FMT_NONE)) |-> ((width == 31'd0) && (height == 31'd0)))
        else $error("invalid file reported with nonzero dimensions");

    a_accept_needs_format: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> ((format != FMT_NONE) && (width != 31'd0)
                                     && (height != 31'd0)))
        else $error("accepted result without a valid format and size");

    a_accept_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> ((width <= max_dimension_reg)
                                     && (height <= max_dimension_reg)))
        else $error("accepted result exceeds the dimension limit");
`endif

endmodule

`default_nettype wire

// ===== sv/ihv_png.sv =====
// PNG chunk walker with bytewise CRC-32 check.
// Depends on ihv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihv_png
    import ihv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire byte_req_t req,
    output dims_t          verdict
);

    png_phase_t  phase_reg, phase_next;
    logic [31:0] counter_reg, counter_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] crc_reg, crc_next;
    logic [31:0] recv_reg, recv_next;
    logic        header_reg, header_next;
    logic        data_reg, data_next;
    logic        end_flag_reg, end_flag_next;
    logic        failed_reg, failed_next;
    logic [63:0] dims_reg, dims_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [31:0] recv_full;
        logic        good;
        b = req.data;
        recv_full = {recv_reg[23:0], b};
        good = 1'b1;
        phase_next = phase_reg;
        counter_next = counter_reg;
        length_next = length_reg;
        type_next = type_reg;
        crc_next = crc_reg;
        recv_next = recv_reg;
        header_next = header_reg;
        data_next = data_reg;
        end_flag_next = end_flag_reg;
        failed_next = failed_reg;
        dims_next = dims_reg;
        case (phase_reg)
            PNG_SIG:
            begin
                if (b != png_sig_byte(counter_reg[2:0]))
                begin
                    failed_next = 1'b1;
                    phase_next = PNG_HALT;
                end
                else if (counter_reg == 32'd7)
                begin
                    phase_next = PNG_LEN;
                    counter_next = 32'd0;
                end
                else
                begin
                    counter_next = counter_reg + 32'd1;
                end
            end
            PNG_LEN:
            begin
                length_next = {length_reg[23:0], b};
                counter_next = counter_reg + 32'd1;
                if (counter_reg == 32'd3)
                begin
                    phase_next = PNG_TYPE;
                    counter_next = 32'd0;
                    type_next = 32'd0;
                    crc_next = CRC_INIT;
                end
            end
            PNG_TYPE:
            begin
                type_next = {type_reg[23:0], b};
                crc_next = crc_byte(crc_reg, b);
                counter_next = counter_reg + 32'd1;
                if (counter_reg == 32'd3)
                begin
                    counter_next = 32'd0;
                    phase_next = (length_reg == 32'd0) ? PNG_CRC : PNG_DATA;
                end
            end
            PNG_DATA:
            begin
                crc_next = crc_byte(crc_reg, b);
                // The first eight data bytes of the header chunk hold width and height.
                if (!header_reg && (counter_reg < 32'd8))
                begin
                    for (int k = 0; k < 8; k++)
                    begin
                        if (counter_reg[2:0] == 3'(k))
                        begin
                            dims_next[8*(7-k) +: 8] = b;
                        end
                    end
                end
                counter_next = counter_reg + 32'd1;
                if (counter_next == length_reg)
                begin
                    phase_next = PNG_CRC;
                    counter_next = 32'd0;
                end
            end
            PNG_CRC:
            begin
                recv_next = recv_full;
                counter_next = counter_reg + 32'd1;
                if (counter_reg == 32'd3)
                begin
                    if ((crc_reg ^ CRC_INIT) != recv_full)
                    begin
                        good = 1'b0;
                    end
                    else if (!header_reg)
                    begin
                        if ((type_reg != TYPE_IHDR) || (length_reg != IHDR_LENGTH)
                            || (dims_reg[63:32] == 32'd0) || (dims_reg[31:0] == 32'd0)
                            || dims_reg[63] || dims_reg[31])
                        begin
                            good = 1'b0;
                        end
                        else
                        begin
                            header_next = 1'b1;
                        end
                    end
                    else if (type_reg == TYPE_IHDR)
                    begin
                        good = 1'b0;
                    end
                    if (good && (type_reg == TYPE_IDAT))
                    begin
                        data_next = 1'b1;
                    end
                    if (good && (type_reg == TYPE_IEND))
                    begin
                        if ((length_reg != 32'd0) || !data_reg)
                        begin
                            good = 1'b0;
                        end
                        else
                        begin
                            end_flag_next = 1'b1;
                            phase_next = PNG_HALT;
                        end
                    end
                    else if (good)
                    begin
                        phase_next = PNG_LEN;
                        counter_next = 32'd0;
                    end
                    if (!good)
                    begin
                        failed_next = 1'b1;
                        phase_next = PNG_HALT;
                    end
                    length_next = 32'd0;
                    recv_next = 32'd0;
                end
            end
            default:
            begin
                failed_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        verdict.valid = end_flag_next && !failed_next;
        verdict.width = dims_next[62:32];
        verdict.height = dims_next[30:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PNG_SIG;
            counter_reg <= 32'd0;
            length_reg <= 32'd0;
            type_reg <= 32'd0;
            crc_reg <= CRC_INIT;
            recv_reg <= 32'd0;
            header_reg <= 1'b0;
            data_reg <= 1'b0;
            end_flag_reg <= 1'b0;
            failed_reg <= 1'b0;
            dims_reg <= 64'd0;
        end
        else if (req.accept)
        begin
            if (req.last)
            begin
                phase_reg <= PNG_SIG;
                counter_reg <= 32'd0;
                length_reg <= 32'd0;
                type_reg <= 32'd0;
                crc_reg <= CRC_INIT;
                recv_reg <= 32'd0;
                header_reg <= 1'b0;
                data_reg <= 1'b0;
                end_flag_reg <= 1'b0;
                failed_reg <= 1'b0;
                dims_reg <= 64'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                counter_reg <= counter_next;
                length_reg <= length_next;
                type_reg <= type_next;
                crc_reg <= crc_next;
                recv_reg <= recv_next;
                header_reg <= header_next;
                data_reg <= data_next;
                end_flag_reg <= end_flag_next;
                failed_reg <= failed_next;
                dims_reg <= dims_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ihv_jpeg.sv =====
// JPEG marker walker that looks for a start-of-frame segment.
// Depends on ihv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihv_jpeg
    import ihv_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire byte_req_t req,
    output dims_t          verdict
);

    jpeg_phase_t phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] length_reg, length_next;
    logic [31:0] dims_reg, dims_next;
    logic        found_reg, found_next;
    logic        complete_reg, complete_next;
    logic        failed_reg, failed_next;
    logic [7:0]  prev_reg;

    always_comb
    begin
        logic [7:0]  b;
        logic [15:0] full_len;
        b = req.data;
        full_len = {length_reg[15:8], b};
        phase_next = phase_reg;
        count_next = count_reg;
        length_next = length_reg;
        dims_next = dims_reg;
        found_next = found_reg;
        complete_next = complete_reg;
        failed_next = failed_reg;
        case (phase_reg)
            JP_START0:
            begin
                if (b != JPEG_FILL)
                begin
                    failed_next = 1'b1;
                    phase_next = JP_HALT;
                end
                else
                begin
                    phase_next = JP_START1;
                end
            end
            JP_START1:
            begin
                if (b != JPEG_SOI)
                begin
                    failed_next = 1'b1;
                    phase_next = JP_HALT;
                end
                else
                begin
                    phase_next = JP_MARKER;
                end
            end
            JP_MARKER:
            begin
                // Fill bytes and standalone markers are skipped.
                if ((b == JPEG_FILL) || (b == 8'h00) || (b == JPEG_SOI) || (b == JPEG_TEM)
                    || ((b >= JPEG_RST_FIRST) && (b <= JPEG_RST_LAST)))
                begin
                    phase_next = JP_MARKER;
                end
                else if ((b == JPEG_EOI) || (b == JPEG_SOS))
                begin
                    failed_next = 1'b1;
                    phase_next = JP_HALT;
                end
                else
                begin
                    found_next = is_sof(b);
                    phase_next = JP_LEN_HI;
                end
            end
            JP_LEN_HI:
            begin
                length_next = {b, 8'd0};
                phase_next = JP_LEN_LO;
            end
            JP_LEN_LO:
            begin
                length_next = full_len;
                count_next = 16'd0;
                if (full_len < 16'd2)
                begin
                    failed_next = 1'b1;
                    phase_next = JP_HALT;
                end
                else if (found_reg)
                begin
                    if (full_len < SOF_MIN_LENGTH)
                    begin
                        failed_next = 1'b1;
                        phase_next = JP_HALT;
                    end
                    else
                    begin
                        phase_next = JP_SOF;
                    end
                end
                else
                begin
                    phase_next = (full_len == 16'd2) ? JP_MARKER : JP_SKIP;
                end
            end
            JP_SKIP:
            begin
                count_next = count_reg + 16'd1;
                if (count_next >= (length_reg - 16'd2))
                begin
                    phase_next = JP_MARKER;
                end
            end
            JP_SOF:
            begin
                // Height comes first in the frame header, then width.
                case (count_reg)
                    16'd1: dims_next[15:8] = b;
                    16'd2: dims_next[7:0] = b;
                    16'd3: dims_next[31:24] = b;
                    16'd4: dims_next[23:16] = b;
                    default: dims_next = dims_reg;
                endcase
                count_next = count_reg + 16'd1;
                if (count_next >= (length_reg - 16'd2))
                begin
                    complete_next = 1'b1;
                    phase_next = JP_HALT;
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    always_comb
    begin
        verdict.valid = complete_next && !failed_next && (prev_reg == JPEG_FILL)
                        && (req.data == JPEG_EOI) && (dims_next[31:16] != 16'd0)
                        && (dims_next[15:0] != 16'd0);
        verdict.width = {15'd0, dims_next[31:16]};
        verdict.height = {15'd0, dims_next[15:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= JP_START0;
            count_reg <= 16'd0;
            length_reg <= 16'd0;
            dims_reg <= 32'd0;
            found_reg <= 1'b0;
            complete_reg <= 1'b0;
            failed_reg <= 1'b0;
            prev_reg <= 8'd0;
        end
        else if (req.accept)
        begin
            if (req.last)
            begin
                phase_reg <= JP_START0;
                count_reg <= 16'd0;
                length_reg <= 16'd0;
                dims_reg <= 32'd0;
                found_reg <= 1'b0;
                complete_reg <= 1'b0;
                failed_reg <= 1'b0;
                prev_reg <= 8'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                length_reg <= length_next;
                dims_reg <= dims_next;
                found_reg <= found_next;
                complete_reg <= complete_next;
                failed_reg <= failed_next;
                prev_reg <= req.data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/ihv_limits.sv =====
// Verdict pipeline: registers the format and dimensions, checks them against
// the configured limits and holds the result for the receiver. Depends on ihv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ihv_limits
    import ihv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic        verdict_valid,
    input  wire format_t     verdict_format,
    input  wire logic [30:0] verdict_width,
    input  wire logic [30:0] verdict_height,
    input  wire logic [30:0] max_dimension,
    input  wire logic [61:0] max_pixels,
    output logic             out_valid,
    output format_t          format,
    output logic [30:0]      width,
    output logic [30:0]      height,
    output logic             accepted
);

    logic        s1_valid_reg;
    format_t     s1_format_reg;
    logic [30:0] s1_width_reg;
    logic [30:0] s1_height_reg;

    logic        s2_valid_reg;
    format_t     s2_format_reg;
    logic [30:0] s2_width_reg;
    logic [30:0] s2_height_reg;
    logic        s2_dim_ok_reg;
    logic [61:0] s2_pixels_reg;

    logic        out_valid_reg;
    format_t     out_format_reg;
    logic [30:0] out_width_reg;
    logic [30:0] out_height_reg;
    logic        out_accepted_reg;

    logic        dim_ok_next;
    logic        accepted_next;

    assign dim_ok_next = (s1_format_reg != FMT_NONE) && (max_dimension != 31'd0)
                         && (s1_width_reg <= max_dimension) && (s1_height_reg <= max_dimension);
    assign accepted_next = s2_dim_ok_reg && (s2_pixels_reg != 62'd0)
                           && (s2_pixels_reg <= max_pixels);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= verdict_valid;
            s2_valid_reg <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_format_reg <= verdict_format;
            s1_width_reg <= verdict_width;
            s1_height_reg <= verdict_height;
            s2_format_reg <= s1_format_reg;
            s2_width_reg <= s1_width_reg;
            s2_height_reg <= s1_height_reg;
            s2_dim_ok_reg <= dim_ok_next;
            s2_pixels_reg <= {31'd0, s1_width_reg} * {31'd0, s1_height_reg};
            out_format_reg <= s2_format_reg;
            out_width_reg <= s2_width_reg;
            out_height_reg <= s2_height_reg;
            out_accepted_reg <= accepted_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign format = out_format_reg;
    assign width = out_width_reg;
    assign height = out_height_reg;
    assign accepted = out_accepted_reg;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for image_header_validator_top: streams generated PNG, JPEG
// and noise files through the block and compares every verdict with a built-in predictor.
// Depends on ihv_pkg and the image_header_validator_top RTL.
`timescale 1ns / 1ps

module testbench;
    import ihv_pkg::*;

    typedef struct {
        format_t     fmt;
        logic [30:0] w;
        logic [30:0] h;
        logic        ok;
    } verdict_t;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ 32'hedb88320) : (r >> 1);
        end
        return r;
    endfunction

    class verdict_board;
        logic [30:0] lim_dim;
        logic [61:0] lim_pix;
        logic [31:0] nbytes;
        png_phase_t  pph;
        logic [31:0] pfc, plen, ptype, pcrc, prcv;
        logic        p_hdr, p_dat, p_end, p_bad;
        logic [63:0] pdim;
        jpeg_phase_t jph;
        logic [31:0] jcnt, jlen, jdim;
        logic        j_sof, j_done, j_bad;
        logic [7:0]  prev;
        verdict_t    verdicts_due[$];
        int          mismatches;
        int          results_seen;

        function new();
            lim_dim = MAX_DIMENSION_RESET;
            lim_pix = MAX_PIXELS_RESET;
            mismatches = 0;
            results_seen = 0;
            clear_parsers();
        endfunction

        function void set_limit(cfg_index_t idx, logic [61:0] v);
            if (idx == CFG_MAX_DIMENSION)
                lim_dim = v[30:0];
            else
                lim_pix = v;
        endfunction

        function void clear_parsers();
            nbytes = 0; pph = PNG_SIG; pfc = 0; plen = 0; ptype = 0;
            pcrc = 32'hffffffff; prcv = 0;
            {p_hdr, p_dat, p_end, p_bad} = 4'b0; pdim = 0;
            jph = JP_START0; jcnt = 0; jlen = 0; jdim = 0;
            {j_sof, j_done, j_bad} = 3'b0; prev = 0;
        endfunction

        function void png_fail();
            p_bad = 1;
            pph = PNG_HALT;
        endfunction

        function void chunk_end();
            logic [31:0] w, h;
            w = pdim[63:32];
            h = pdim[31:0];
            if ((pcrc ^ 32'hffffffff) != prcv) begin png_fail(); return; end
            if (!p_hdr)
            begin
                if (ptype != TYPE_IHDR || plen != 13 || w == 0 || h == 0 || w[31] || h[31])
                begin
                    png_fail();
                    return;
                end
                p_hdr = 1;
            end
            else if (ptype == TYPE_IHDR)
            begin
                png_fail();
                return;
            end
            if (ptype == TYPE_IDAT)
                p_dat = 1;
            if (ptype == TYPE_IEND)
            begin
                if (plen != 0 || !p_dat) begin png_fail(); return; end
                p_end = 1;
                pph = PNG_HALT;
                return;
            end
            pph = PNG_LEN;
            pfc = 0;
        endfunction

        function void png_take(logic [7:0] b);
            int sh;
            case (pph)
                PNG_SIG:
                begin
                    if (b != png_sig_byte(pfc[2:0])) png_fail();
                    else
                    begin
                        pfc++;
                        if (pfc == 8) begin pph = PNG_LEN; pfc = 0; end
                    end
                end
                PNG_LEN:
                begin
                    plen = {plen[23:0], b};
                    pfc++;
                    if (pfc == 4)
                    begin
                        pph = PNG_TYPE; pfc = 0; ptype = 0; pcrc = 32'hffffffff;
                    end
                end
                PNG_TYPE:
                begin
                    ptype = {ptype[23:0], b};
                    pcrc = crc_step(pcrc, b);
                    pfc++;
                    if (pfc == 4)
                    begin
                        pfc = 0;
                        pph = (plen == 0) ? PNG_CRC : PNG_DATA;
                    end
                end
                PNG_DATA:
                begin
                    pcrc = crc_step(pcrc, b);
                    if (!p_hdr && pfc < 8)
                    begin
                        sh = (7 - pfc) * 8;
                        pdim = (pdim & ~(64'hff << sh)) | (64'(b) << sh);
                    end
                    pfc++;
                    if (pfc == plen) begin pph = PNG_CRC; pfc = 0; end
                end
                PNG_CRC:
                begin
                    prcv = {prcv[23:0], b};
                    pfc++;
                    if (pfc == 4)
                    begin
                        chunk_end();
                        plen = 0;
                        prcv = 0;
                    end
                end
                default: p_bad = 1;
            endcase
        endfunction

        function void jpeg_fail();
            j_bad = 1;
            jph = JP_HALT;
        endfunction

        function void jpeg_take(logic [7:0] b);
            case (jph)
                JP_START0: if (b != 8'hff) jpeg_fail(); else jph = JP_START1;
                JP_START1: if (b != 8'hd8) jpeg_fail(); else jph = JP_MARKER;
                JP_MARKER:
                begin
                    if (b == 8'hff || b == 8'h00 || b == 8'hd8 || b == 8'h01 ||
                        (b >= 8'hd0 && b <= 8'hd7))
                        ;
                    else if (b == 8'hd9 || b == 8'hda)
                        jpeg_fail();
                    else
                    begin
                        j_sof = (b[7:4] == 4'hc) && b != 8'hc4 && b != 8'hc8 && b != 8'hcc;
                        jph = JP_LEN_HI;
                    end
                end
                JP_LEN_HI:
                begin
                    jlen = {16'd0, b, 8'd0};
                    jph = JP_LEN_LO;
                end
                JP_LEN_LO:
                begin
                    jlen[7:0] = b;
                    jcnt = 0;
                    if (jlen < 2) jpeg_fail();
                    else if (j_sof)
                    begin
                        if (jlen < 7) jpeg_fail(); else jph = JP_SOF;
                    end
                    else
                        jph = (jlen == 2) ? JP_MARKER : JP_SKIP;
                end
                JP_SKIP:
                begin
                    jcnt++;
                    if (jcnt >= jlen - 2) jph = JP_MARKER;
                end
                JP_SOF:
                begin
                    case (jcnt)
                        1: jdim[15:8] = b;
                        2: jdim[7:0] = b;
                        3: jdim[31:24] = b;
                        4: jdim[23:16] = b;
                        default: ;
                    endcase
                    jcnt++;
                    if (jcnt >= jlen - 2) begin j_done = 1; jph = JP_HALT; end
                end
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            verdict_t v;
            logic [31:0] w, h;
            logic [63:0] px;
            if (nbytes != 32'hffffffff) nbytes++;
            png_take(b);
            jpeg_take(b);
            if (!last)
            begin
                prev = b;
                return;
            end
            v.fmt = FMT_NONE; w = 0; h = 0; v.ok = 0;
            if (p_end && !p_bad)
            begin
                v.fmt = FMT_PNG; w = pdim[63:32]; h = pdim[31:0];
            end
            else if (j_done && !j_bad && nbytes >= 4 && prev == 8'hff && b == 8'hd9 &&
                     jdim[31:16] != 0 && jdim[15:0] != 0)
            begin
                v.fmt = FMT_JPEG; w = {16'd0, jdim[31:16]}; h = {16'd0, jdim[15:0]};
            end
            if (v.fmt != FMT_NONE && lim_dim != 0 && w <= lim_dim && h <= lim_dim)
            begin
                px = 64'(w) * 64'(h);
                v.ok = (px > 0 && px <= 64'(lim_pix));
            end
            v.w = w[30:0];
            v.h = h[30:0];
            verdicts_due = {verdicts_due, v};
            clear_parsers();
        endfunction

        function void check_verdict(logic [1:0] f, logic [30:0] w, logic [30:0] h, logic ok);
            verdict_t e;
            results_seen++;
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict: format %0d width %0d height %0d accepted %0d",
                             f, w, h, ok);
                return;
            end
            e = verdicts_due.pop_front();
            if (f !== e.fmt || w !== e.w || h !== e.h || ok !== e.ok)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("verdict mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             e.fmt, e.w, e.h, e.ok, f, w, h, ok);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [7:0]  data_byte = 0;
    logic        is_last = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [1:0]  format;
    logic [30:0] width;
    logic [30:0] height;
    logic        accepted;
    logic        cfg_write_en = 0;
    logic        cfg_index = 0;
    logic [61:0] cfg_data = 0;

    image_header_validator_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte), .is_last(is_last),
        .out_valid(out_valid), .out_ready(out_ready), .format(format), .width(width),
        .height(height), .accepted(accepted),
        .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    verdict_board board = new();
    logic       byte_taken = 0;
    logic [7:0] file_q[$];
    int         bytes_sent = 0;
    int         burst_left = 0;
    int         rx_cycle = 0;
    int         rx_mode = 0;
    int         stall_left = 0;

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        byte_taken = in_valid && in_ready;
        if (byte_taken)
            board.note_byte(data_byte, is_last);
        if (out_valid && out_ready)
            board.check_verdict(format, width, height, accepted);
    end

    // Receiver: ready always, ready at random, or long stalls, switching now and then.
    always @(negedge clk)
    begin
        rx_cycle++;
        if (rx_cycle % 97 == 0)
            rx_mode = $urandom_range(0, 2);
        case (rx_mode)
            0: out_ready = 1;
            1: out_ready = $urandom_range(0, 1);
            default:
            begin
                if (stall_left > 0)
                begin
                    out_ready = 0;
                    stall_left--;
                end
                else
                begin
                    out_ready = 1;
                    stall_left = $urandom_range(0, 15);
                end
            end
        endcase
    end

    initial
    begin
        #10_000_000;
        $display("image_header_validator_top regression: fail");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (burst_left == 0)
        begin
            in_valid = 0;
            repeat ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid = 1;
        data_byte = b;
        is_last = last;
        do @(negedge clk); while (!byte_taken);
        bytes_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == file_q.size() - 1);
        in_valid = 0;
    endtask

    task automatic drain();
        in_valid = 0;
        while (board.verdicts_due.size() != 0)
            @(negedge clk);
        repeat (5) @(negedge clk);
    endtask

    task automatic write_limit(input cfg_index_t idx, input logic [61:0] v);
        cfg_write_en = 1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_write_en = 0;
        board.set_limit(idx, v);
    endtask

    task automatic append_byte(input logic [7:0] b);
        file_q.insert(file_q.size(), b);
    endtask

    task automatic put32(input logic [31:0] v);
        for (int i = 3; i >= 0; i--)
            append_byte(v[i*8 +: 8]);
    endtask

    task automatic put_chunk(input logic [31:0] kind, input logic [7:0] body[$], input bit bad_crc);
        logic [31:0] c;
        c = 32'hffffffff;
        put32(body.size());
        put32(kind);
        for (int i = 0; i < 4; i++)
            c = crc_step(c, kind[(3-i)*8 +: 8]);
        foreach (body[i])
        begin
            append_byte(body[i]);
            c = crc_step(c, body[i]);
        end
        if (bad_crc)
            c[$urandom_range(0, 31)] ^= 1'b1;
        put32(c ^ 32'hffffffff);
    endtask

    function automatic logic [31:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 32'd1;
            1: return 32'h7fffffff;
            2: return $urandom;
            3: return (3 == $urandom_range(0, 3)) ? 32'd0 : 32'h80000000;
            4: return $urandom_range(4000, 5000);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    // Broken files: a flipped bit, a cut-off tail or extra trailing bytes; half the time the file stays intact.
    task automatic mangle();
        int pos;
        case ($urandom_range(0, 5))
            0:
            begin
                pos = $urandom_range(0, file_q.size() - 1);
                file_q[pos][$urandom_range(0, 7)] ^= 1'b1;
            end
            1: repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
            2: repeat ($urandom_range(1, 3)) append_byte(8'($urandom));
            default: ;
        endcase
    endtask

    task automatic build_png(input bit clean);
        logic [7:0] body[$];
        logic [31:0] w, h;
        bit flaw;
        file_q.delete();
        for (int i = 0; i < 8; i++)
            append_byte(png_sig_byte(3'(i)));
        w = clean ? $urandom_range(1, 6000) : pick_dim();
        h = clean ? $urandom_range(1, 6000) : pick_dim();
        body.delete();
        for (int i = 3; i >= 0; i--) body = {body, w[i*8 +: 8]};
        for (int i = 3; i >= 0; i--) body = {body, h[i*8 +: 8]};
        repeat (5) body = {body, 8'($urandom)};
        if (!clean && $urandom_range(0, 9) == 0)
            body = {body, 8'($urandom)};
        flaw = !clean && $urandom_range(0, 5) == 0;
        put_chunk((!clean && $urandom_range(0, 12) == 0) ? TYPE_IDAT : TYPE_IHDR, body, flaw);
        if ($urandom_range(0, 2) == 0)
        begin
            body.delete();
            repeat ($urandom_range(0, 6)) body = {body, 8'($urandom)};
            put_chunk(32'h74455874, body, 0);
        end
        if (clean || $urandom_range(0, 6) != 0)
        begin
            body.delete();
            repeat ($urandom_range(0, 10)) body = {body, 8'($urandom)};
            put_chunk(TYPE_IDAT, body, !clean && $urandom_range(0, 8) == 0);
        end
        if (!clean && $urandom_range(0, 10) == 0)
        begin
            body.delete();
            repeat (13) body = {body, 8'($urandom)};
            put_chunk(TYPE_IHDR, body, 0);
        end
        body.delete();
        if (!clean && $urandom_range(0, 10) == 0)
            body = {body, 8'($urandom)};
        put_chunk(TYPE_IEND, body, 0);
        if (!clean)
            mangle();
    endtask

    task automatic build_jpeg(input bit clean);
        logic [7:0] sof_codes[$] = '{8'hc0, 8'hc1, 8'hc2, 8'hc3, 8'hc5, 8'hc6, 8'hc7,
                                     8'hc9, 8'hca, 8'hcb, 8'hcd, 8'hce, 8'hcf};
        logic [7:0] skip_codes[$] = '{8'hff, 8'h00, 8'h01, 8'hd8, 8'hd0, 8'hd3, 8'hd7};
        logic [15:0] len, w, h;
        file_q.delete();
        append_byte(JPEG_FILL);
        append_byte(JPEG_SOI);
        repeat ($urandom_range(0, 2))
        begin
            repeat ($urandom_range(0, 2))
                append_byte(skip_codes[$urandom_range(0, skip_codes.size() - 1)]);
            append_byte(8'hff);
            append_byte($urandom_range(0, 1) ? 8'hc4 : 8'(8'he0 + $urandom_range(0, 15)));
            len = 16'($urandom_range(2, 8));
            if (!clean && $urandom_range(0, 15) == 0) len = 16'($urandom_range(0, 1));
            append_byte(len[15:8]);
            append_byte(len[7:0]);
            repeat (len > 2 ? len - 2 : 0) append_byte(8'($urandom));
        end
        if (!clean && $urandom_range(0, 15) == 0)
        begin
            append_byte(8'hff);
            append_byte($urandom_range(0, 1) ? JPEG_SOS : JPEG_EOI);
        end
        append_byte(8'hff);
        append_byte(sof_codes[$urandom_range(0, sof_codes.size() - 1)]);
        len = 16'($urandom_range(7, 11));
        if (!clean && $urandom_range(0, 12) == 0) len = 16'($urandom_range(2, 6));
        case (clean ? 0 : $urandom_range(0, 5))
            1: begin w = 16'hffff; h = 16'hffff; end
            2: begin w = 16'($urandom_range(0, 1)); h = 16'($urandom_range(0, 1)); end
            3: begin w = 16'($urandom); h = 16'($urandom); end
            default:
            begin
                w = 16'($urandom_range(1, 5000));
                h = 16'($urandom_range(1, 5000));
            end
        endcase
        append_byte(len[15:8]);
        append_byte(len[7:0]);
        append_byte(8'd8);
        append_byte(h[15:8]);
        append_byte(h[7:0]);
        append_byte(w[15:8]);
        append_byte(w[7:0]);
        repeat (len > 7 ? len - 7 : 0) append_byte(8'($urandom));
        repeat ($urandom_range(0, 6)) append_byte(8'($urandom));
        append_byte(8'hff);
        append_byte(JPEG_EOI);
        if (!clean)
            mangle();
    endtask

    task automatic build_noise();
        file_q.delete();
        repeat ($urandom_range(1, 12)) append_byte(8'($urandom));
    endtask

    task automatic random_files(input int byte_goal, input int verdict_goal);
        int start_bytes, start_results, pick;
        start_bytes = bytes_sent;
        start_results = board.results_seen;
        while (bytes_sent - start_bytes < byte_goal ||
               board.results_seen - start_results < verdict_goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4) build_png(pick == 0);
            else if (pick < 8) build_jpeg(pick == 4);
            else build_noise();
            send_file();
            if ($urandom_range(0, 15) == 0)
                drain();
        end
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: one-byte file, a bare start/end pair, minimal valid JPEG and a clean random PNG.
        file_q = '{8'hff};
        send_file();
        file_q = '{8'hff, 8'hd8, 8'hff, 8'hd9};
        send_file();
        file_q = '{8'hff, 8'hd8, 8'hff, 8'hc0, 8'h00, 8'h07, 8'h08, 8'h00, 8'h01,
                   8'h00, 8'h01, 8'hff, 8'hd9};
        send_file();
        build_png(1);
        send_file();
        drain();

        random_files(450, 12);
        drain();
        write_limit(CFG_MAX_DIMENSION, 62'd0);
        random_files(250, 8);
        drain();
        write_limit(CFG_MAX_DIMENSION, {62{1'b1}});
        write_limit(CFG_MAX_PIXELS, {62{1'b1}});
        random_files(400, 10);
        drain();
        write_limit(CFG_MAX_DIMENSION, 62'd300);
        write_limit(CFG_MAX_PIXELS, 62'd0);
        random_files(200, 6);
        drain();
        write_limit(CFG_MAX_DIMENSION, 62'($urandom_range(100, 6000)));
        write_limit(CFG_MAX_PIXELS, 62'($urandom_range(1000, 9_000_000)));
        random_files(350, 10);

        drain();
        repeat (20) @(negedge clk);
        if (board.mismatches == 0 && board.verdicts_due.size() == 0)
            $display("image_header_validator_top regression: pass");
        else
            $display("image_header_validator_top regression: fail");
        $finish;
    end

endmodule
